// ===== rtl/stok_pkg.sv =====
// Package for the source tokenizer: widths, token kinds, scan modes, result type.
// No dependencies.
package stok_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 16;

  localparam logic [4:0] K_IF     = 5'd0;
  localparam logic [4:0] K_ELSE   = 5'd1;
  localparam logic [4:0] K_WHILE  = 5'd2;
  localparam logic [4:0] K_FOR    = 5'd3;
  localparam logic [4:0] K_LET    = 5'd4;
  localparam logic [4:0] K_GOTO   = 5'd5;
  localparam logic [4:0] K_IDENT  = 5'd6;
  localparam logic [4:0] K_NUMBER = 5'd7;
  localparam logic [4:0] K_STRING = 5'd8;
  localparam logic [4:0] K_PLUS   = 5'd9;
  localparam logic [4:0] K_MINUS  = 5'd10;
  localparam logic [4:0] K_STAR   = 5'd11;
  localparam logic [4:0] K_SLASH  = 5'd12;
  localparam logic [4:0] K_ASSIGN = 5'd13;
  localparam logic [4:0] K_EQ     = 5'd14;
  localparam logic [4:0] K_NOT    = 5'd15;
  localparam logic [4:0] K_NE     = 5'd16;
  localparam logic [4:0] K_LT     = 5'd17;
  localparam logic [4:0] K_GT     = 5'd18;
  localparam logic [4:0] K_LE     = 5'd19;
  localparam logic [4:0] K_GE     = 5'd20;
  localparam logic [4:0] K_LPAREN = 5'd21;
  localparam logic [4:0] K_RPAREN = 5'd22;
  localparam logic [4:0] K_LBRACE = 5'd23;
  localparam logic [4:0] K_RBRACE = 5'd24;
  localparam logic [4:0] K_COMMA  = 5'd25;
  localparam logic [4:0] K_DOT    = 5'd26;
  localparam logic [4:0] K_SEMI   = 5'd27;
  localparam logic [4:0] K_COLON  = 5'd28;
  localparam logic [4:0] K_EOF    = 5'd29;
  localparam logic [4:0] K_ERROR  = 5'd30;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNEXP    = 3'd1;
  localparam logic [2:0] E_DOT2     = 3'd2;
  localparam logic [2:0] E_UNTERM   = 3'd3;
  localparam logic [2:0] E_BADESC   = 3'd4;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_IDENT   = 8'b0000_0010,
    M_NUMBER  = 8'b0000_0100,
    M_STRING  = 8'b0000_1000,
    M_ESCAPE  = 8'b0001_0000,
    M_SLASH   = 8'b0010_0000,
    M_COMMENT = 8'b0100_0000,
    M_OPEQ    = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [4:0]             kind;
    logic [2:0]             error_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line_no;
    logic [LINE_BITS-1:0]   column_no;
  } result_t;

  // Up to two results per byte.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } pair_t;

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h2C:   k = K_COMMA;
      8'h2E:   k = K_DOT;
      8'h3B:   k = K_SEMI;
      8'h3A:   k = K_COLON;
      default: k = K_IF;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/source_tokenizer_unit.sv =====
// Source tokenizer: byte stream in, token stream out, one byte per cycle unless stalled.
// Depends on stok_pkg, stok_scan and stok_outq.
//
// Takes one source byte per transaction (0 ends the source) and returns tokens
// with kind, error code, start offset, length and the line/column after the
// token. A byte is taken every cycle while the four-entry result queue has
// room for two results; a byte yields none, one or two results, the last of
// them flagged with out_tlast. Each result is registered in the result queue
// before it reaches the output. Tokens needing lookahead (idents, numbers,
// the =, !, < and > operators, slash) appear with the following byte.
module source_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // kind[4:0] error_kind[7:5] start_offset[31:8]
                                   // token_length[55:32] line_no[71:56] column_no[87:72]
  output logic        out_tlast
);

  stok_pkg::pair_t   pr;
  stok_pkg::result_t od;
  logic step, space;

  assign in_tready = space;
  assign step = in_tvalid && in_tready;

  stok_scan u_scan (.clk, .rst_n, .step, .ch(in_tdata), .res(pr));

  stok_outq u_q (
    .clk, .rst_n, .wr(step), .pr, .space,
    .o_valid(out_tvalid), .o_ready(out_tready), .o_data(od), .o_last(out_tlast)
  );

  assign out_tdata = {8'b0, od.column_no, od.line_no, od.token_length,
                      od.start_offset, od.error_kind, od.kind};

  // A second result implies a first
  a_pair: assert property (@(posedge clk) disable iff (!rst_n) !pr.v1 || pr.v0)
    else $error("second result without first");
  // Output kind stays within the defined range
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= stok_pkg::K_ERROR)
    else $error("bad kind");
  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

endmodule

// ===== rtl/stok_scan.sv =====
// Scanner: mode machine, counters, token builder; one byte per step cycle.
// Depends on stok_pkg.
module stok_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  output stok_pkg::pair_t   res
);

  localparam int OB = stok_pkg::OFFSET_BITS;
  localparam int LB = stok_pkg::LINE_BITS;

  stok_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        dot_r, dot_nxt;
  logic [OB-1:0] start_r, start_nxt, cnt_r, cnt_nxt, pos_r, pos_nxt;
  logic [39:0] kw_r, kw_nxt;
  logic [LB-1:0] line_r, line_nxt, col_r, col_nxt;

  logic alpha, digit, c_zero, ws, fr;
  logic [4:0] idk, sk, opk_n, opk_e;
  logic [39:0] kwtext;

  assign alpha  = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign digit  = ch >= 8'h30 && ch <= 8'h39;
  assign c_zero = ch == 8'h00;
  assign ws     = ch == 8'h20 || ch == 8'h09 || ch == 8'h0A;
  assign sk     = stok_pkg::single_kind(ch);

  // Keyword match on the held first five bytes
  always_comb begin
    idk = stok_pkg::K_IDENT;
    if      (cnt_r == OB'(2) && kw_r == 40'h0000006669)   idk = stok_pkg::K_IF;
    else if (cnt_r == OB'(4) && kw_r == 40'h0065736C65)   idk = stok_pkg::K_ELSE;
    else if (cnt_r == OB'(5) && kw_r == 40'h656C696877)   idk = stok_pkg::K_WHILE;
    else if (cnt_r == OB'(3) && kw_r == 40'h0000726F66)   idk = stok_pkg::K_FOR;
    else if (cnt_r == OB'(3) && kw_r == 40'h000074656C)   idk = stok_pkg::K_LET;
    else if (cnt_r == OB'(4) && kw_r == 40'h006F746F67)   idk = stok_pkg::K_GOTO;
  end

  always_comb begin
    case (pend_r)
      8'h3D:   begin opk_n = stok_pkg::K_ASSIGN; opk_e = stok_pkg::K_EQ; end
      8'h21:   begin opk_n = stok_pkg::K_NOT;    opk_e = stok_pkg::K_NE; end
      8'h3C:   begin opk_n = stok_pkg::K_LT;     opk_e = stok_pkg::K_LE; end
      default: begin opk_n = stok_pkg::K_GT;     opk_e = stok_pkg::K_GE; end
    endcase
  end
  assign kwtext = '0;

  always_comb begin
    logic cons, addc, e0, e1;
    logic [4:0] k0, k1;
    logic [2:0] er0, er1;
    logic [OB-1:0] st0, st1, ln0, ln1;
    logic tok_begin, upd_line;
    logic [LB-1:0] l_pre, c_pre, l_cons, c_cons;
    stok_pkg::mode_t fm;

    mode_nxt = mode_r; pend_nxt = pend_r; dot_nxt = dot_r;
    start_nxt = start_r; cnt_nxt = cnt_r; kw_nxt = kw_r; pos_nxt = pos_r;
    cons = 1'b0; addc = 1'b0; fr = 1'b0; e0 = 1'b0; e1 = 1'b0;
    k0 = '0; k1 = '0; er0 = stok_pkg::E_NONE; er1 = stok_pkg::E_NONE;
    st0 = start_r; st1 = start_r; ln0 = cnt_r; ln1 = '0;
    tok_begin = 1'b0; fm = stok_pkg::M_IDLE;

    case (mode_r)
      stok_pkg::M_IDENT: begin
        if (alpha || digit || ch == 8'h5F) addc = 1'b1;
        else begin e0 = 1'b1; k0 = idk; fr = 1'b1; end
      end
      stok_pkg::M_NUMBER: begin
        if (digit) addc = 1'b1;
        else if (ch == 8'h2E && !dot_r) begin dot_nxt = 1'b1; addc = 1'b1; end
        else if (ch == 8'h2E) begin
          e0 = 1'b1; k0 = stok_pkg::K_ERROR; er0 = stok_pkg::E_DOT2; ln0 = '0; fr = 1'b1;
        end else begin e0 = 1'b1; k0 = stok_pkg::K_NUMBER; fr = 1'b1; end
      end
      stok_pkg::M_STRING: begin
        if (c_zero) begin
          e0 = 1'b1; k0 = stok_pkg::K_ERROR; er0 = stok_pkg::E_UNTERM; ln0 = '0; fr = 1'b1;
        end else if (ch == 8'h22) begin
          addc = 1'b1; e0 = 1'b1; k0 = stok_pkg::K_STRING; mode_nxt = stok_pkg::M_IDLE;
        end else if (ch == 8'h5C) begin addc = 1'b1; mode_nxt = stok_pkg::M_ESCAPE; end
        else addc = 1'b1;
      end
      stok_pkg::M_ESCAPE: begin
        if (ch == 8'h6E || ch == 8'h22 || ch == 8'h5C) begin
          addc = 1'b1; mode_nxt = stok_pkg::M_STRING;
        end else begin
          e0 = 1'b1; k0 = stok_pkg::K_ERROR; er0 = stok_pkg::E_BADESC; ln0 = '0; fr = 1'b1;
        end
      end
      stok_pkg::M_SLASH: begin
        if (ch == 8'h2F) begin cons = 1'b1; mode_nxt = stok_pkg::M_COMMENT; end
        else begin e0 = 1'b1; k0 = stok_pkg::K_SLASH; fr = 1'b1; end
      end
      stok_pkg::M_COMMENT: begin
        if (ch == 8'h0A || c_zero) fr = 1'b1;
        else cons = 1'b1;
      end
      stok_pkg::M_OPEQ: begin
        if (ch == 8'h3D) begin
          addc = 1'b1; e0 = 1'b1; k0 = opk_e; mode_nxt = stok_pkg::M_IDLE;
        end else begin e0 = 1'b1; k0 = opk_n; fr = 1'b1; end
      end
      default: fr = 1'b1;
    endcase

    // Fresh scan of the byte (after any token the old mode closed)
    if (fr) begin
      mode_nxt = stok_pkg::M_IDLE;
      if (c_zero) begin
        e1 = 1'b1; k1 = stok_pkg::K_EOF; st1 = pos_r;
      end else if (ws) cons = 1'b1;
      else begin
        tok_begin = 1'b1;
        if (alpha) begin addc = 1'b1; fm = stok_pkg::M_IDENT; end
        else if (digit) begin addc = 1'b1; dot_nxt = 1'b0; fm = stok_pkg::M_NUMBER; end
        else if (ch == 8'h22) begin addc = 1'b1; fm = stok_pkg::M_STRING; end
        else if (ch == 8'h2F) begin addc = 1'b1; fm = stok_pkg::M_SLASH; end
        else if (ch == 8'h3D || ch == 8'h21 || ch == 8'h3C || ch == 8'h3E) begin
          addc = 1'b1; pend_nxt = ch; fm = stok_pkg::M_OPEQ;
        end else if (sk != stok_pkg::K_IF) begin
          addc = 1'b1; e1 = 1'b1; k1 = sk; st1 = pos_r; ln1 = OB'(1);
        end else begin
          cons = 1'b1; e1 = 1'b1; k1 = stok_pkg::K_ERROR; er1 = stok_pkg::E_UNEXP;
          st1 = pos_r; ln1 = '0;
        end
        mode_nxt = fm;
      end
    end

    if (tok_begin) begin
      start_nxt = pos_r;
      cnt_nxt = '0;
      kw_nxt = '0;
    end
    if (addc) begin
      if (cnt_nxt < OB'(5)) kw_nxt[cnt_nxt[2:0]*8 +: 8] = ch;
      if (cnt_nxt != '1) cnt_nxt = cnt_nxt + OB'(1);
      cons = 1'b1;
    end
    upd_line = cons && ch == 8'h0A;
    l_cons = upd_line ? ((line_r != '1) ? line_r + LB'(1) : line_r) : line_r;
    c_cons = upd_line ? LB'(1) : ((col_r != '1) ? col_r + LB'(1) : col_r);
    line_nxt = cons ? l_cons : line_r;
    col_nxt  = cons ? c_cons : col_r;
    if (cons && pos_r != '1) pos_nxt = pos_r + OB'(1);

    // A token closed by the old mode sees counters after this byte only when
    // the byte was part of it (string end, two-char operator).
    l_pre = fr ? line_r : line_nxt;
    c_pre = fr ? col_r : col_nxt;
    if (!fr && e0) ln0 = cnt_nxt;

    res.v0 = e0 | e1;
    res.v1 = e0 & e1;
    res.r0.kind = e0 ? k0 : k1;
    res.r0.error_kind = e0 ? er0 : er1;
    res.r0.start_offset = e0 ? st0 : st1;
    res.r0.token_length = e0 ? ln0 : ln1;
    res.r0.line_no = e0 ? l_pre : line_nxt;
    res.r0.column_no = e0 ? c_pre : col_nxt;
    res.r1.kind = k1;
    res.r1.error_kind = er1;
    res.r1.start_offset = st1;
    res.r1.token_length = ln1;
    res.r1.line_no = line_nxt;
    res.r1.column_no = col_nxt;
    if (!step) begin
      mode_nxt = mode_r; pend_nxt = pend_r; dot_nxt = dot_r; start_nxt = start_r;
      cnt_nxt = cnt_r; kw_nxt = kw_r; pos_nxt = pos_r; line_nxt = line_r; col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stok_pkg::M_IDLE;
      pend_r <= '0; dot_r <= 1'b0; start_r <= '0; cnt_r <= '0; kw_r <= kwtext;
      pos_r <= '0; line_r <= LB'(1); col_r <= LB'(1);
    end else begin
      mode_r <= mode_nxt; pend_r <= pend_nxt; dot_r <= dot_nxt; start_r <= start_nxt;
      cnt_r <= cnt_nxt; kw_r <= kw_nxt; pos_r <= pos_nxt; line_r <= line_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ===== rtl/stok_outq.sv =====
// Result queue: holds up to two pending result pairs' worth of results (4 deep).
// Depends on stok_pkg.
module stok_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  stok_pkg::pair_t   pr,
  output logic              space,
  output logic              o_valid,
  input  logic              o_ready,
  output stok_pkg::result_t o_data,
  output logic              o_last
);

  typedef struct packed {
    stok_pkg::result_t r;
    logic              l;
  } ent_t;

  ent_t q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic pop;
  logic [1:0] nwr;

  assign pop     = o_valid && o_ready;
  assign nwr     = wr ? (pr.v1 ? 2'd2 : (pr.v0 ? 2'd1 : 2'd0)) : 2'd0;
  assign o_valid = cnt_r != 3'd0;
  assign o_data  = q_r[rd_r].r;
  assign o_last  = q_r[rd_r].l;
  // Room for a full pair, without counting on a pop this cycle
  assign space   = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (nwr != 2'd0) begin
      q_r[wr_r].r <= pr.r0;
      q_r[wr_r].l <= !pr.v1;
    end
    if (nwr == 2'd2) begin
      q_r[wr_r + 2'd1].r <= pr.r1;
      q_r[wr_r + 2'd1].l <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + nwr;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, nwr} - {2'b0, pop};
    end
  end

endmodule

// ===== bench/tb_source_tokenizer_unit.sv =====
// Testbench for source_tokenizer_unit: byte stream in, token stream checked
// against a behavioural lexer model held here. Depends on stok_pkg and the RTL.
`timescale 1ns / 1ps

module tb_source_tokenizer_unit;

  // local scan states of the behavioural model
  typedef enum int {
    S_IDLE, S_IDENT, S_NUMBER, S_STRING, S_ESCAPE, S_SLASH, S_COMMENT, S_OPEQ
  } scan_t;

  typedef struct {
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [23:0] start;
    logic [23:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tlast;

  source_tokenizer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  // model state
  scan_t       lx_mode = S_IDLE;
  logic [7:0]  lx_pend = 8'd0;
  logic        lx_dot = 1'b0;
  logic [23:0] lx_start = '0;
  logic [23:0] lx_count = '0;
  logic [39:0] lx_kwbuf = '0;
  logic [23:0] lx_pos = '0;
  logic [15:0] lx_line = 16'd1;
  logic [15:0] lx_col = 16'd1;

  token_t token_q[$];     // tokens the block still owes
  int     n_bad = 0;
  int     n_tokens = 0;
  int     n_bytes = 0;
  int     idle_cycles = 0;
  bit     send_gaps = 1'b1;
  bit     recv_gaps = 1'b1;
  bit     stall_req = 1'b0; // asks the sink for a long hold-off
  int     hold_off = 0;     // hold-off cycles, counted down by the sink

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic lx_consume(logic [7:0] c);
    if (lx_pos != 24'hFF_FFFF) lx_pos++;
    if (c == "\n") begin
      if (lx_line != 16'hFFFF) lx_line++;
      lx_col = 16'd1;
    end else if (lx_col != 16'hFFFF) begin
      lx_col++;
    end
  endtask

  task automatic lx_add(logic [7:0] c);
    if (lx_count < 5) lx_kwbuf[8*lx_count +: 8] = c;
    if (lx_count != 24'hFF_FFFF) lx_count++;
    lx_consume(c);
  endtask

  task automatic lx_push(logic [4:0] k, logic [2:0] e, logic [23:0] s, logic [23:0] l);
    token_t t;
    t.kind = k; t.err = e; t.start = s; t.len = l;
    t.line = lx_line; t.col = lx_col; t.last = 1'b0;
    token_q.push_back(t);
  endtask

  function automatic logic [4:0] word_kind(logic [23:0] cnt, logic [39:0] b);
    if (cnt == 2 && b[15:0] == "fi") return stok_pkg::K_IF;
    if (cnt == 4 && b[31:0] == "esle") return stok_pkg::K_ELSE;
    if (cnt == 5 && b[39:0] == "elihw") return stok_pkg::K_WHILE;
    if (cnt == 3 && b[23:0] == "rof") return stok_pkg::K_FOR;
    if (cnt == 3 && b[23:0] == "tel") return stok_pkg::K_LET;
    if (cnt == 4 && b[31:0] == "otog") return stok_pkg::K_GOTO;
    return stok_pkg::K_IDENT;
  endfunction

  function automatic logic [4:0] cmp_kind(logic [7:0] op, bit eq);
    case (op)
      "=": return eq ? stok_pkg::K_EQ : stok_pkg::K_ASSIGN;
      "!": return eq ? stok_pkg::K_NE : stok_pkg::K_NOT;
      "<": return eq ? stok_pkg::K_LE : stok_pkg::K_LT;
      default: return eq ? stok_pkg::K_GE : stok_pkg::K_GT;
    endcase
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] c);
    case (c)
      "+": return stok_pkg::K_PLUS;
      "-": return stok_pkg::K_MINUS;
      "*": return stok_pkg::K_STAR;
      "(": return stok_pkg::K_LPAREN;
      ")": return stok_pkg::K_RPAREN;
      "{": return stok_pkg::K_LBRACE;
      "}": return stok_pkg::K_RBRACE;
      ",": return stok_pkg::K_COMMA;
      ".": return stok_pkg::K_DOT;
      ";": return stok_pkg::K_SEMI;
      ":": return stok_pkg::K_COLON;
      default: return stok_pkg::K_IF; // K_IF doubles as "no token"
    endcase
  endfunction

  // byte seen outside any token
  task automatic lx_fresh(logic [7:0] c);
    logic [4:0] k;
    lx_mode = S_IDLE;
    if (c == 8'd0) begin
      lx_push(stok_pkg::K_EOF, stok_pkg::E_NONE, lx_pos, '0);
      return;
    end
    if (c == " " || c == "\t" || c == "\n") begin
      lx_consume(c);
      return;
    end
    lx_start = lx_pos; lx_count = '0; lx_kwbuf = '0;
    k = punct_kind(c);
    if (is_alpha(c)) begin
      lx_add(c); lx_mode = S_IDENT;
    end else if (is_digit(c)) begin
      lx_add(c); lx_dot = 1'b0; lx_mode = S_NUMBER;
    end else if (c == "\"") begin
      lx_add(c); lx_mode = S_STRING;
    end else if (c == "/") begin
      lx_add(c); lx_mode = S_SLASH;
    end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
      lx_add(c); lx_pend = c; lx_mode = S_OPEQ;
    end else if (k != stok_pkg::K_IF) begin
      lx_add(c); lx_push(k, stok_pkg::E_NONE, lx_start, lx_count);
    end else begin
      lx_consume(c); lx_push(stok_pkg::K_ERROR, stok_pkg::E_UNEXP, lx_start, '0);
    end
  endtask

  // advance the model by one byte, queueing the tokens it yields
  task automatic lex_byte(logic [7:0] c);
    int n_prev;
    n_prev = token_q.size();
    case (lx_mode)
      S_IDENT:
        if (is_alpha(c) || is_digit(c) || c == "_") lx_add(c);
        else begin
          lx_push(word_kind(lx_count, lx_kwbuf), stok_pkg::E_NONE, lx_start, lx_count);
          lx_fresh(c);
        end
      S_NUMBER:
        if (is_digit(c)) lx_add(c);
        else if (c == "." && !lx_dot) begin
          lx_dot = 1'b1; lx_add(c);
        end else if (c == ".") begin
          lx_push(stok_pkg::K_ERROR, stok_pkg::E_DOT2, lx_start, '0); lx_fresh(c);
        end else begin
          lx_push(stok_pkg::K_NUMBER, stok_pkg::E_NONE, lx_start, lx_count); lx_fresh(c);
        end
      S_STRING:
        if (c == 8'd0) begin
          lx_push(stok_pkg::K_ERROR, stok_pkg::E_UNTERM, lx_start, '0); lx_fresh(c);
        end else if (c == "\"") begin
          lx_add(c);
          lx_push(stok_pkg::K_STRING, stok_pkg::E_NONE, lx_start, lx_count);
          lx_mode = S_IDLE;
        end else if (c == "\\") begin
          lx_add(c); lx_mode = S_ESCAPE;
        end else lx_add(c);
      S_ESCAPE:
        if (c == "n" || c == "\"" || c == "\\") begin
          lx_add(c); lx_mode = S_STRING;
        end else begin
          lx_push(stok_pkg::K_ERROR, stok_pkg::E_BADESC, lx_start, '0); lx_fresh(c);
        end
      S_SLASH:
        if (c == "/") begin
          lx_consume(c); lx_mode = S_COMMENT;
        end else begin
          lx_push(stok_pkg::K_SLASH, stok_pkg::E_NONE, lx_start, lx_count); lx_fresh(c);
        end
      S_COMMENT:
        if (c == "\n" || c == 8'd0) lx_fresh(c);
        else lx_consume(c);
      S_OPEQ:
        if (c == "=") begin
          lx_add(c);
          lx_push(cmp_kind(lx_pend, 1'b1), stok_pkg::E_NONE, lx_start, lx_count);
          lx_mode = S_IDLE;
        end else begin
          lx_push(cmp_kind(lx_pend, 1'b0), stok_pkg::E_NONE, lx_start, lx_count);
          lx_fresh(c);
        end
      default: lx_fresh(c);
    endcase
    if (token_q.size() > n_prev) token_q[$].last = 1'b1;
  endtask

  // one byte transaction; model updated on acceptance; tvalid stays up
  // until a gap or a drain takes it down
  task automatic send_byte(logic [7:0] c);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tdata <= c;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_byte(c);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
  endtask

  // result sink: gaps, long hold-off, field check
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req = 1'b0;
      hold_off = 300;
    end
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off--;
    end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      hold_off = $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    token_t exp_t;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      n_tokens++;
      if (token_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected token %h last %b", out_tdata, out_tlast);
      end else begin
        exp_t = token_q.pop_front();
        if (out_tdata[4:0] !== exp_t.kind || out_tdata[7:5] !== exp_t.err ||
            out_tdata[31:8] !== exp_t.start || out_tdata[55:32] !== exp_t.len ||
            out_tdata[71:56] !== exp_t.line || out_tdata[87:72] !== exp_t.col ||
            out_tdata[95:88] !== 8'd0 || out_tlast !== exp_t.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp k%0d e%0d s%0d l%0d ln%0d c%0d t%b | got %h t%b",
                     exp_t.kind, exp_t.err, exp_t.start, exp_t.len, exp_t.line,
                     exp_t.col, exp_t.last, out_tdata, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d tokens outstanding", token_q.size());
      $display("** source_tokenizer_unit: FAILED **");
      $finish;
    end
  end

  // --- tests ---
  task automatic test_keywords_and_idents;
    send_text("if else while for let goto iff els whilex Ab_9 z\n");
  endtask

  task automatic test_numbers;
    send_text("0 123.45 7.8.9 1. ");
  endtask

  task automatic test_strings;
    send_text("\"\" \"a\\n\\\"\\\\b\" \"x\\q ");
    send_byte(8'd0);               // eof after the bad escape
    send_text("\"abc");
    send_byte(8'd0);
  endtask

  task automatic test_operators;
    send_text("+-*(){},.;: = == ! != < <= > >= / a/b x=y ");
    send_text("// comment to the end\n//c");
    send_byte(8'd0);
    send_text("<");
    send_byte(8'd0);               // pending operator at end of source
    send_byte(8'd0);               // repeated eof
    send_text("_ @#");
    send_byte(8'hFF);
    send_byte(8'h80);
  endtask

  // random source fragments, some malformed, mixed with noise
  task automatic test_random(int n_items, bit pressure);
    string frag[] = '{"if", "else", "while", "for", "let", "goto", "foo", "x_1",
                      "42", "3.14", "1.2.3", "\"hi\\n\"", "\"a\\\\b\"", "\"q\\z",
                      "==", "!=", "<=", ">=", "=", "!", "<", ">", "/", "// note\n",
                      "+", "-", "*", "(", ")", "{", "}", ",", ".", ";", ":",
                      " ", "\t", "\n", "  "};
    int sent;
    string s;
    sent = 0;
    while (sent < n_items) begin
      if (pressure && sent > 200 && sent < 210) stall_req = 1'b1;
      case ($urandom_range(0, 19))
        0: begin send_byte(8'($urandom_range(0, 255))); sent++; end
        1: begin send_byte(8'd0); sent++; end
        default: begin
          s = frag[$urandom_range(0, frag.size() - 1)];
          send_text(s);
          sent += s.len();
          if ($urandom_range(0, 2) == 0) begin send_byte(" "); sent++; end
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_keywords_and_idents();
    test_numbers();
    test_strings();
    test_operators();
    drain();                       // sender pauses until everything is back
    test_random(1100, 1'b1);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(400, 1'b0);
    send_byte(8'd0);
    drain();
    repeat (20) @(negedge clk);
    $display("sent %0d bytes, checked %0d tokens (keywords, numbers, strings, operators,",
             n_bytes, n_tokens);
    $display("comments, eof and every error kind), with gaps and a long output stall");
    if (n_bad == 0 && token_q.size() == 0) begin
      $display("** source_tokenizer_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d tokens missing", n_bad, token_q.size());
      $display("** source_tokenizer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/stok_pkg.sv
rtl/stok_scan.sv
rtl/stok_outq.sv
rtl/source_tokenizer_unit.sv
bench/tb_source_tokenizer_unit.sv
